[sv/region_depth_from_disparity_macros.svh]
// Assertion helpers for the region depth block
`ifndef REGION_DEPTH_FROM_DISPARITY_MACROS_SVH
`define REGION_DEPTH_FROM_DISPARITY_MACROS_SVH

// Implication checked on every clock edge outside reset
`define RDD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define RDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rdd_pkg.sv]
package rdd_pkg;

  localparam int MAX_SPAN_DEF        = 32;
  localparam int DISP_FRAC_BITS_DEF  = 4;
  localparam int MIN_DISP_MARGIN_DEF = 12;

  localparam int CW  = 12;
  localparam int RW  = 48;
  localparam int DW  = 16;
  localparam int MDW = 9;
  localparam int CNTW = 11;
  localparam int QW  = 73;
  localparam int QSTEPS = 73;

  localparam logic [2:0] REG_MIN_DISP = 3'd0;
  localparam logic [2:0] REG_BASELINE = 3'd1;
  localparam logic [2:0] REG_W_OFFSET = 3'd2;
  localparam logic [2:0] REG_FOCAL    = 3'd3;
  localparam logic [2:0] REG_CENTER_X = 3'd4;
  localparam logic [2:0] REG_CENTER_Y = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_VALID = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_WCHK,
    S_DIVZ,
    S_DIVY,
    S_DIVX,
    S_FOLD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    Q_Z,
    Q_Y,
    Q_X
  } qsel_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

[sv/rdd_mul.sv]
module rdd_mul (
  input  logic                     clk,
  input  logic                     start,
  input  logic signed [17:0]       a,
  input  logic signed [47:0]       b,
  input  logic signed [47:0]       c,
  output logic                     done,
  output logic signed [66:0]       p
);
  import rdd_pkg::*;

  logic signed [66:0] acc_r, acc_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic signed [47:0] b_r;
  logic signed [17:0] a_r;
  logic signed [66:0] pp;

  always_comb begin
    pp = 67'(a_r * $signed({1'b0, b_r[23:0]}));
    acc_nxt = acc_r;
    ph_nxt = ph_r;
    if (start) begin
      acc_nxt = 67'(c);
      ph_nxt = 2'd1;
    end else if (ph_r == 2'd1) begin
      acc_nxt = acc_r + pp;
      ph_nxt = 2'd2;
    end else if (ph_r == 2'd2) begin
      acc_nxt = acc_r + (67'(a_r * $signed(b_r[47:24])) <<< 24);
      ph_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    acc_r <= acc_nxt;
    ph_r <= ph_nxt;
  end

  assign p = acc_r;
  assign done = (ph_r == 2'd0);
endmodule

[sv/rdd_div.sv]
module rdd_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [66:0]    num,
  input  logic signed [66:0]    den,
  output rdd_pkg::div_ctl_t     ctl,
  output logic signed [47:0]    q
);
  import rdd_pkg::*;

  logic [65:0] mn_r, md_r;
  logic [67:0] rem_r, rem_nxt;
  logic [46:0] q_r, q_nxt;
  logic        over_r, over_nxt, neg_r, busy_r;
  logic [6:0]  b_r;
  logic [67:0] sh;
  logic        bit_in;
  logic [66:0] an, ad;

  always_comb begin
    an = num[66] ? 67'(-num) : num;
    ad = den[66] ? 67'(-den) : den;
    bit_in = (b_r >= 7'd24) ? mn_r[b_r - 7'd24] : 1'b0;
    sh = {rem_r[66:0], bit_in};
    rem_nxt = sh;
    q_nxt = q_r;
    over_nxt = over_r;
    if (sh >= {2'b0, md_r}) begin
      rem_nxt = sh - {2'b0, md_r};
      if (b_r >= 7'd47) over_nxt = 1'b1;
      else q_nxt[b_r[5:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      b_r <= 7'(QSTEPS - 1);
      mn_r <= an[65:0];
      md_r <= ad[65:0];
      neg_r <= num[66] ^ den[66];
      rem_r <= '0;
      q_r <= '0;
      over_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r <= q_nxt;
      over_r <= over_nxt;
      if (b_r == 7'd0) busy_r <= 1'b0;
      else b_r <= b_r - 7'd1;
    end
  end

  always_comb begin
    if (neg_r) q = over_r ? {1'b1, 47'd0} : 48'(-$signed({1'b0, q_r}));
    else       q = over_r ? {1'b0, {47{1'b1}}} : {1'b0, q_r};
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = !busy_r;
endmodule

[sv/region_depth_from_disparity.sv]
// Channel  Direction  Payload
// in       input      corners, pixel col/row, raw disparity, first/last marks
// out      output     status, region_disp, world_x/y/z
// cfg      input      min_disp, baseline_term, w_offset, focal, center_x, center_y
// A counted pixel that clears MIN_DISP_MARGIN holds in_ready low for a three-step
// multiply for w, a w check, three 73-step restoring divisions on one divider, a fold
// and a finish step; the w check skips to finish if w is 0. Other pixels only finish.
// Reset is synchronous, active low, and clears the running region state.
// A region's last pixel waits in its finish step while the previous result is unclaimed.
module region_depth_from_disparity #(
  parameter int MAX_SPAN        = rdd_pkg::MAX_SPAN_DEF,
  parameter int DISP_FRAC_BITS  = rdd_pkg::DISP_FRAC_BITS_DEF,
  parameter int MIN_DISP_MARGIN = rdd_pkg::MIN_DISP_MARGIN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [11:0]          in_corner_x0,
  input  logic [11:0]          in_corner_y0,
  input  logic [11:0]          in_corner_x1,
  input  logic [11:0]          in_corner_y1,
  input  logic [11:0]          in_pixel_col,
  input  logic [11:0]          in_pixel_row,
  input  logic signed [15:0]   in_raw_disparity,
  input  logic                 in_first_pixel,
  input  logic                 in_last_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic signed [15:0]   out_region_disp,
  output logic signed [47:0]   out_world_x,
  output logic signed [47:0]   out_world_y,
  output logic signed [47:0]   out_world_z
);
  import rdd_pkg::*;

  logic signed [8:0]  min_disp_r;
  logic signed [47:0] baseline_r, w_off_r, focal_r, cx_r, cy_r;

  state_t state_r, state_nxt;
  logic [10:0] seen_r;
  logic signed [17:0] rdisp_r;
  logic signed [47:0] rx_r, ry_r, rz_r, qz_r, qy_r;
  logic stopped_r, over_r, last_r;
  logic signed [17:0] val_r;
  logic [11:0] col_r, row_r;
  logic signed [66:0] w_r;
  logic out_v_r;
  logic [1:0] st_r;
  logic signed [15:0] od_r;
  logic signed [47:0] ox_r, oy_r, oz_r;

  logic acc, ld_out;
  logic [12:0] dx, dy;
  logic ovs, in_rect, st_clear, skip, cnt_val;
  logic signed [17:0] val_c, skipv, raw_c;
  logic stop_c;
  logic [10:0] seen_c;

  logic mul_start, mul_done;
  logic signed [66:0] mul_p;
  logic div_start;
  logic signed [66:0] div_num;
  div_ctl_t dctl;
  logic signed [47:0] div_q;

  rdd_mul u_mul (.clk(clk), .start(mul_start), .a(val_c), .b(baseline_r),
    .c(w_off_r), .done(mul_done), .p(mul_p));
  rdd_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(w_r), .ctl(dctl), .q(div_q));

  assign acc = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign ld_out = (state_r == S_DONE) && last_r && (!out_v_r || out_ready);

  always_comb begin
    dx = (in_corner_x0 > in_corner_x1) ? 13'(in_corner_x0 - in_corner_x1)
                                       : 13'(in_corner_x1 - in_corner_x0);
    dy = (in_corner_y0 > in_corner_y1) ? 13'(in_corner_y0 - in_corner_y1)
                                       : 13'(in_corner_y1 - in_corner_y0);
    ovs = (in_first_pixel ? 1'b0 : over_r) || dx > 13'(MAX_SPAN) || dy > 13'(MAX_SPAN);
    in_rect = in_pixel_col >= in_corner_x0 && in_pixel_col <= in_corner_x1 &&
              in_pixel_row >= in_corner_y0 && in_pixel_row <= in_corner_y1;
    st_clear = in_first_pixel ? 1'b0 : stopped_r;
    if (in_rect && in_pixel_col == in_corner_x0) st_clear = 1'b0;
    skipv = 18'(($signed({min_disp_r[8], min_disp_r}) - 10'sd1)) <<< DISP_FRAC_BITS;
    skip = 18'(in_raw_disparity) == skipv;
    cnt_val = !ovs && in_rect && !st_clear && !skip;
    seen_c = in_first_pixel ? 11'd0 : seen_r;
    if (cnt_val && seen_c != 11'd2047) seen_c = seen_c + 11'd1;
    // truncate toward zero
    raw_c = 18'(in_raw_disparity);
    if (raw_c[17]) raw_c = raw_c + 18'((1 << DISP_FRAC_BITS) - 1);
    val_c = (raw_c >>> DISP_FRAC_BITS) + 18'(min_disp_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc) state_nxt = (cnt_val && val_c >= 18'(min_disp_r) +
                18'(MIN_DISP_MARGIN)) ? S_MUL : S_DONE;
      S_MUL:  if (mul_done) state_nxt = S_WCHK;
      S_WCHK: state_nxt = (w_r == '0) ? S_DONE : S_DIVZ;
      S_DIVZ: if (dctl.done && !dctl.start) state_nxt = S_DIVY;
      S_DIVY: if (dctl.done && !dctl.start) state_nxt = S_DIVX;
      S_DIVX: if (dctl.done && !dctl.start) state_nxt = S_FOLD;
      S_FOLD: state_nxt = S_DONE;
      S_DONE: state_nxt = (last_r && out_v_r && !out_ready) ? S_DONE : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic div_go_r;
  always_comb begin
    mul_start = (state_r == S_IDLE) && acc;
    div_start = div_go_r;
    unique case (state_r)
      S_DIVY:  div_num = 67'({1'b0, row_r, 32'd0}) + 67'(cy_r);
      S_DIVX:  div_num = 67'({1'b0, col_r, 32'd0}) + 67'(cx_r);
      default: div_num = 67'(focal_r);
    endcase
  end

  logic signed [48:0] fz, fy, fx;
  logic signed [18:0] fd;
  always_comb begin
    fz = (49'(rz_r) + 49'(qz_r)) / 49'sd2;
    fy = (49'(ry_r) + 49'(qy_r)) / 49'sd2;
    fx = (49'(rx_r) + 49'(div_q)) / 49'sd2;
    fd = (19'(rdisp_r) + 19'(val_r)) / 19'sd2;
    if (seen_r > 11'd1) stop_c = fz[47:0] == '0 || fy[47:0] == '0 || fx[47:0] == '0;
    else                stop_c = qz_r == '0 || qy_r == '0 || div_q == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      min_disp_r <= '0; baseline_r <= '0; w_off_r <= '0;
      focal_r <= '0; cx_r <= '0; cy_r <= '0;
      seen_r <= '0; rdisp_r <= '0; rx_r <= '0; ry_r <= '0; rz_r <= '0;
      stopped_r <= 1'b0; over_r <= 1'b0; out_v_r <= 1'b0; div_go_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      div_go_r <= (state_r == S_WCHK && w_r != '0) ||
                  (state_r == S_DIVZ && state_nxt == S_DIVY) ||
                  (state_r == S_DIVY && state_nxt == S_DIVX);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_DISP: min_disp_r <= cfg_data[8:0];
          REG_BASELINE: baseline_r <= cfg_data;
          REG_W_OFFSET: w_off_r <= cfg_data;
          REG_FOCAL:    focal_r <= cfg_data;
          REG_CENTER_X: cx_r <= cfg_data;
          REG_CENTER_Y: cy_r <= cfg_data;
          default: ;
        endcase
      end
      if (acc) begin
        over_r <= ovs;
        stopped_r <= st_clear;
        seen_r <= seen_c;
        last_r <= in_last_pixel;
        val_r <= val_c;
        col_r <= in_pixel_col;
        row_r <= in_pixel_row;
        if (in_first_pixel) begin
          rdisp_r <= '0; rx_r <= '0; ry_r <= '0; rz_r <= '0;
        end
      end
      if (state_r == S_MUL && mul_done) w_r <= mul_p;
      if (state_r == S_DIVY && div_start) qz_r <= div_q;
      if (state_r == S_DIVX && div_start) qy_r <= div_q;
      if (state_r == S_FOLD) begin
        if (seen_r > 11'd1) begin
          rdisp_r <= 18'(fd); rz_r <= fz[47:0]; ry_r <= fy[47:0]; rx_r <= fx[47:0];
        end else begin
          rdisp_r <= val_r; rz_r <= qz_r; ry_r <= qy_r; rx_r <= div_q;
        end
        if (stop_c) stopped_r <= 1'b1;
      end
      if (ld_out) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  logic signed [15:0] md1;
  always_comb md1 = 16'($signed({min_disp_r[8], min_disp_r}) - 10'sd1);

  always_ff @(posedge clk) begin
    if (ld_out) begin
      if (over_r) begin
        st_r <= ST_TOO_BIG; od_r <= md1;
        ox_r <= '1; oy_r <= '1; oz_r <= '1;
      end else if (seen_r != '0 && rx_r != '0 && ry_r != '0 && rz_r != '0) begin
        st_r <= ST_OK; od_r <= rdisp_r[15:0];
        ox_r <= rx_r; oy_r <= ry_r; oz_r <= rz_r;
      end else begin
        st_r <= ST_NO_VALID; od_r <= md1;
        ox_r <= '0; oy_r <= '0; oz_r <= '0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_status = st_r;
  assign out_region_disp = od_r;
  assign out_world_x = ox_r;
  assign out_world_y = oy_r;
  assign out_world_z = oz_r;
endmodule

[sv/rdd_checker.sv]
`include "region_depth_from_disparity_macros.svh"
module rdd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status
);
  import rdd_pkg::*;
  `RDD_ASSERT_NEXT(a_stable, clk, rst_n, out_valid && !out_ready, $stable(out_status), "status changed while waiting")
  `RDD_ASSERT_IMP(a_status, clk, rst_n, out_valid, out_status != 2'd3, "bad status")
  `RDD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `RDD_ASSERT_NEXT(a_acc, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
endmodule

bind region_depth_from_disparity rdd_checker u_chk (.clk(clk), .rst_n(rst_n),
  .in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_status(out_status));
